[hw/rtl/amacd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amacd_pkg
// Shared constants and types for the moving-average change detector.
// ----------------------------------------------------------------------------
package amacd_pkg;

  localparam int WINDOW       = 10;
  localparam int SAMPLE_BITS  = 16;
  localparam int THRESH_BITS  = 15;
  localparam int SLOT_BITS    = $clog2(WINDOW);
  localparam int SUM_BITS     = SAMPLE_BITS + $clog2(WINDOW);
  localparam int LIMIT_BITS   = THRESH_BITS + $clog2(WINDOW);
  localparam int DATA_BITS    = 3 * SAMPLE_BITS;
  localparam int IN_BYTES     = (DATA_BITS + 7) / 8;
  localparam int OUT_BYTES    = 1;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(26);
  localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  =
    LIMIT_BITS'(26 * WINDOW);

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic        [LIMIT_BITS-1:0]  limit_t;
  typedef logic        [SLOT_BITS-1:0]   slot_t;

  // per-axis control from the top level
  typedef struct packed {
    logic  push;
    logic  tick;
    slot_t slot;
  } axis_ctrl_t;

  // result word, x flag in bit 0
  typedef struct packed {
    logic any_change;
    logic change_z;
    logic change_y;
    logic change_x;
  } flags_t;

endpackage

[hw/rtl/accel_moving_average_change_detect.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_moving_average_change_detect
// Three-axis moving-average change detector over per-axis sample rings with a shared write slot.
// ----------------------------------------------------------------------------
// A tick word's result goes into the output register, or into the skid when that register is full.
// Throughput: one input word per cycle while the skid is empty; sample words give no result.
// A two-entry output stage (result register plus skid) holds tick results.
// Reset clears rings, window sums, saved sums, write slot and output stage,
// and sets change_threshold to 26 (0.10 in Q8.8).
module accel_moving_average_change_detect (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [amacd_pkg::THRESH_BITS-1:0]   cfg_wr_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // accel_x [15:0], accel_y [31:16], accel_z [47:32]
  input  logic [8*amacd_pkg::IN_BYTES-1:0]    s_axis_tdata,
  // op
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // change_x [0], change_y [1], change_z [2], any_change [3], zero [7:4]
  output logic [8*amacd_pkg::OUT_BYTES-1:0]   m_axis_tdata
);
  import amacd_pkg::*;

  limit_t     limit;
  slot_t      write_slot;
  axis_ctrl_t ctrl;
  logic       s_fire;
  logic       pop;
  logic [2:0] change;
  flags_t     flags_new;
  flags_t     out_word;
  flags_t     skid_word;
  logic       out_valid;
  logic       skid_valid;

  assign s_axis_tready = !skid_valid;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid && m_axis_tready;

  assign ctrl.push = s_fire && (s_axis_tuser == OP_SAMPLE);
  assign ctrl.tick = s_fire && (s_axis_tuser == OP_TICK);
  assign ctrl.slot = write_slot;

  amacd_axis u_axis_x (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .sample (s_axis_tdata[SAMPLE_BITS-1:0]),
    .limit  (limit),
    .change (change[0])
  );

  amacd_axis u_axis_y (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .sample (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .limit  (limit),
    .change (change[1])
  );

  amacd_axis u_axis_z (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .sample (s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
    .limit  (limit),
    .change (change[2])
  );

  always_comb begin
    flags_new.change_x   = change[0];
    flags_new.change_y   = change[1];
    flags_new.change_z   = change[2];
    flags_new.any_change = |change;
  end

  // threshold kept pre-scaled by the window size
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit <= LIMIT_BITS'(cfg_wr_data) * LIMIT_BITS'(WINDOW);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
    end else if (ctrl.push) begin
      if (write_slot == SLOT_BITS'(WINDOW - 1)) begin
        write_slot <= '0;
      end else begin
        write_slot <= write_slot + 1'b1;
      end
    end
  end

  // output register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_word   <= skid_word;
        skid_valid <= 1'b0;
      end else if (ctrl.tick) begin
        out_word <= flags_new;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (ctrl.tick) begin
      if (!out_valid) begin
        out_word  <= flags_new;
        out_valid <= 1'b1;
      end else begin
        skid_word  <= flags_new;
        skid_valid <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(8*OUT_BYTES-4)'(0), out_word};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a word while output register is empty");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    write_slot <= SLOT_BITS'(WINDOW - 1))
    else $error("write slot out of range");

  a_tick_gives_word: assert property (@(posedge clk) disable iff (rst)
    ctrl.tick |=> out_valid)
    else $error("tick word produced no result");

  a_sample_no_word: assert property (@(posedge clk) disable iff (rst)
    (!ctrl.tick && !pop) |=> (out_valid == $past(out_valid)) &&
                             (skid_valid == $past(skid_valid)))
    else $error("output stage changed without tick or pop");

  a_any_is_or: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.any_change ==
                   (out_word.change_x || out_word.change_y || out_word.change_z)))
    else $error("any_change does not match axis flags");

endmodule

[hw/rtl/amacd_axis.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amacd_axis
// One axis: sample ring, running window sum, saved sum and change flag.
// ----------------------------------------------------------------------------
module amacd_axis (
  input  logic                  clk,
  input  logic                  rst,
  input  amacd_pkg::axis_ctrl_t ctrl,
  input  amacd_pkg::sample_t    sample,
  input  amacd_pkg::limit_t     limit,
  output logic                  change
);
  import amacd_pkg::*;

  sample_t ring [WINDOW];
  sum_t    sum;
  sum_t    sum_next;
  sum_t    saved;

  logic signed [SUM_BITS:0] diff;
  logic        [SUM_BITS:0] mag;

  assign sum_next = sum - SUM_BITS'(ring[ctrl.slot]) + SUM_BITS'(sample);

  assign diff = {sum[SUM_BITS-1], sum} - {saved[SUM_BITS-1], saved};
  assign mag  = diff[SUM_BITS] ? (SUM_BITS+1)'(-diff) : diff;
  assign change = (mag > (SUM_BITS+1)'(limit));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring[i] <= '0;
      end
      sum   <= '0;
      saved <= '0;
    end else begin
      if (ctrl.push) begin
        ring[ctrl.slot] <= sample;
        sum             <= sum_next;
      end
      if (ctrl.tick) begin
        saved <= sum;
      end
    end
  end

endmodule

[verif/amacd_change_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amacd_change_checker
// Watches the sample/tick stream and the flag stream of the change detector.
// Keeps its own rings, window sums and saved sums, predicts the flag word for
// every accepted tick, and compares accepted flag words in order.
// ----------------------------------------------------------------------------
module amacd_change_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [amacd_pkg::THRESH_BITS-1:0]   cfg_wr_data,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  // accel_x [15:0], accel_y [31:16], accel_z [47:32]
  input  logic [8*amacd_pkg::IN_BYTES-1:0]    s_axis_tdata,
  // op
  input  logic                                s_axis_tuser,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // change_x [0], change_y [1], change_z [2], any_change [3], zero [7:4]
  input  logic [8*amacd_pkg::OUT_BYTES-1:0]   m_axis_tdata,
  output int                                  mismatch_count,
  output int                                  flags_pending,
  output int                                  samples_taken,
  output int                                  ticks_taken,
  output int                                  flags_checked
);
  import amacd_pkg::*;

  sample_t                ring [3][WINDOW];
  sum_t                   win_sum [3];
  sum_t                   tick_sum [3];
  slot_t                  wr_slot;
  logic [THRESH_BITS-1:0] thresh;
  flags_t                 pending_flags [$];

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic take_sample(logic [8*IN_BYTES-1:0] word);
    sample_t s;
    for (int a = 0; a < 3; a++) begin
      s = word[SAMPLE_BITS*a +: SAMPLE_BITS];
      win_sum[a] = win_sum[a] - ring[a][wr_slot] + s;
      ring[a][wr_slot] = s;
    end
    wr_slot = (wr_slot == slot_t'(WINDOW - 1)) ? '0 : wr_slot + 1'b1;
  endtask

  // compare sums, not averages: |sum - saved| > threshold * WINDOW
  function automatic flags_t detect_change();
    logic signed [SUM_BITS:0] diff;
    logic [SUM_BITS:0]        mag;
    logic [LIMIT_BITS-1:0]    lim;
    logic [2:0]               hit;
    flags_t                   f;
    lim = LIMIT_BITS'(thresh) * LIMIT_BITS'(WINDOW);
    for (int a = 0; a < 3; a++) begin
      diff = win_sum[a] - tick_sum[a];
      mag = (diff < 0) ? -diff : diff;
      hit[a] = (mag > lim);
      tick_sum[a] = win_sum[a];
    end
    f.change_x = hit[0];
    f.change_y = hit[1];
    f.change_z = hit[2];
    f.any_change = |hit;
    return f;
  endfunction

  always @(posedge clk) begin : watch
    flags_t got;
    flags_t want;
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < WINDOW; i++) ring[a][i] = '0;
        win_sum[a] = '0;
        tick_sum[a] = '0;
      end
      wr_slot = '0;
      thresh = THRESH_RESET;
      pending_flags.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_flags.size() == 0) begin
          report_mismatch("flag word with none pending", m_axis_tdata, 0);
        end else begin
          got = flags_t'(m_axis_tdata[3:0]);
          want = pending_flags.pop_front();
          flags_checked++;
          if (got.change_x !== want.change_x)
            report_mismatch("change_x", got.change_x, want.change_x);
          if (got.change_y !== want.change_y)
            report_mismatch("change_y", got.change_y, want.change_y);
          if (got.change_z !== want.change_z)
            report_mismatch("change_z", got.change_z, want.change_z);
          if (got.any_change !== want.any_change)
            report_mismatch("any_change", got.any_change, want.any_change);
          if (m_axis_tdata[7:4] !== 4'b0000)
            report_mismatch("pad bits", m_axis_tdata[7:4], 0);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_TICK) begin
          pending_flags.push_back(detect_change());
          ticks_taken++;
        end else begin
          take_sample(s_axis_tdata);
          samples_taken++;
        end
      end
      if (cfg_wr_en) thresh = cfg_wr_data;
    end
    flags_pending = pending_flags.size();
  end

endmodule

[verif/accel_moving_average_change_detect_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_moving_average_change_detect_tb
// Drives sample and tick words with bursty timing and a stalling receiver,
// across several threshold settings, and leaves checking to the checker.
// ----------------------------------------------------------------------------
module accel_moving_average_change_detect_tb;
  import amacd_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 8;
  localparam int PHASE_WORDS    = 150;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [THRESH_BITS-1:0] cfg_wr_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // accel_x [15:0], accel_y [31:16], accel_z [47:32]
  logic [8*IN_BYTES-1:0]  s_axis_tdata = '0;
  // op
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // change_x [0], change_y [1], change_z [2], any_change [3], zero [7:4]
  logic [8*OUT_BYTES-1:0] m_axis_tdata;

  int mismatch_count;
  int flags_pending;
  int samples_taken;
  int ticks_taken;
  int flags_checked;

  int hold_req = 0;
  int hold_done = 0;
  int rx_stall_pct = 0;
  int run_left = 0;
  logic run_ready = 1'b1;
  int burst_left = 0;
  int gap_max = 0;
  int thresholds_set = 0;
  int stuck_cycles = 0;

  accel_moving_average_change_detect DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  amacd_change_checker flag_watch (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .mismatch_count (mismatch_count),
    .flags_pending  (flags_pending),
    .samples_taken  (samples_taken),
    .ticks_taken    (ticks_taken),
    .flags_checked  (flags_checked)
  );

  always #5 clk = ~clk;

  // receiver: runs of ready/stall, plus a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = hold_req;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 8);
          run_ready = ($urandom_range(99) >= rx_stall_pct);
        end
        run_left--;
        m_axis_tready = run_ready;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL accel_moving_average_change_detect");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_word(logic op, sample_t x, sample_t y, sample_t z);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_max > 0) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = {z, y, x};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (flags_pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_threshold(int v);
    drain();
    cfg_wr_en = 1'b1;
    cfg_wr_data = THRESH_BITS'(v);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    thresholds_set++;
  endtask

  function automatic sample_t rand_sample(int amp);
    if (amp >= 32768) return sample_t'($urandom);
    return sample_t'(int'($urandom_range(2 * amp)) - amp);
  endfunction

  // spread of samples relative to the threshold, so flags come out mixed
  function automatic int pick_amp(int thr);
    int a;
    case ($urandom_range(3))
      0: a = thr / 2 + 1;
      1: a = 2 * thr + 8;
      2: a = 8 * thr + 64;
      default: a = 32768;
    endcase
    return (a > 32768) ? 32768 : a;
  endfunction

  initial begin : stimulus
    int thr;
    int amp;
    int tick_pct;
    logic op;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // default threshold 26: limit 260 on the sums
    send_word(OP_TICK, 0, 0, 0);
    send_word(OP_SAMPLE, 32767, -32768, 0);
    send_word(OP_TICK, 0, 0, 0);
    send_word(OP_TICK, -1, 32767, -32768);
    send_word(OP_SAMPLE, 260, -260, -1);
    send_word(OP_TICK, 0, 0, 0);
    send_word(OP_SAMPLE, 1, -1, 261);
    send_word(OP_TICK, 0, 0, 0);

    // largest threshold, full window at both extremes
    set_threshold(32767);
    repeat (WINDOW) send_word(OP_SAMPLE, 32767, -32768, -1);
    send_word(OP_TICK, 0, 0, 0);
    repeat (WINDOW) send_word(OP_SAMPLE, -32768, 32767, 0);
    send_word(OP_TICK, 0, 0, 0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: thr = 0;
        1: thr = 32767;
        2: thr = $urandom_range(32767);
        default: thr = $urandom_range(400);
      endcase
      set_threshold(thr);
      rx_stall_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 70);
      gap_max = (p % 4 == 1) ? 0 : $urandom_range(2, 10);
      tick_pct = $urandom_range(5, 40);
      if (p == 3) begin
        // long output stall while ticks keep coming
        hold_req++;
        gap_max = 0;
        repeat (30) send_word(OP_TICK, rand_sample(32768), rand_sample(32768),
                              rand_sample(32768));
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i % 30 == 0) amp = pick_amp(thr);
        op = ($urandom_range(99) < tick_pct) ? OP_TICK : OP_SAMPLE;
        send_word(op, rand_sample(amp), rand_sample(amp), rand_sample(amp));
      end
    end

    drain();
    $display("Run covered %0d sample words and %0d tick words; %0d flag words checked.",
             samples_taken, ticks_taken, flags_checked);
    $display("%0d threshold writes from 0 to 32767, random stalls and one long hold-off.",
             thresholds_set);
    if (mismatch_count == 0) begin
      $display("PASS accel_moving_average_change_detect");
    end else begin
      $display("FAIL accel_moving_average_change_detect");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/amacd_pkg.sv
hw/rtl/amacd_axis.sv
hw/rtl/accel_moving_average_change_detect.sv
verif/amacd_change_checker.sv
verif/accel_moving_average_change_detect_tb.sv
